// ----- src/packed_array_list_engine_macros.svh -----
// Assertion macros used by the checker file.
`ifndef PACKED_ARRAY_LIST_ENGINE_MACROS_SVH
`define PACKED_ARRAY_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, held off during reset
`define PAL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("list engine check failed");

// Next-cycle implication, held off during reset
`define PAL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("list engine check failed");

`endif

// ----- src/pal_pkg.sv -----
`timescale 1ns / 1ps

package pal_pkg;

  // Operation codes
  localparam logic [2:0] OP_CLEAR    = 3'd0;
  localparam logic [2:0] OP_INS_AT   = 3'd1;
  localparam logic [2:0] OP_INS_LAST = 3'd2;
  localparam logic [2:0] OP_DEL_AT   = 3'd3;
  localparam logic [2:0] OP_DEL_LAST = 3'd4;
  localparam logic [2:0] OP_GET_SET  = 3'd5;
  localparam logic [2:0] OP_SEARCH   = 3'd6;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic start;        // capture request value, clear working result
    logic mem_wr;       // write the entry store
    logic wr_use_value; // write data is the request value, else the read data
    logic mem_rd;       // read the entry store into the read register
    logic load_read;    // take the read register as the get result
    logic cmp;          // compare the read register against the request value
    logic publish;      // move working result into the output registers
  } pal_cmd_t;

endpackage

// ----- src/pal_dpath.sv -----
`timescale 1ns / 1ps

module pal_dpath #(
  parameter int DEPTH      = 32,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                     clk,
  input  pal_pkg::pal_cmd_t        cmd,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic [ELEM_WIDTH-1:0]    in_value,
  output logic [ELEM_WIDTH-1:0]    out_read_value,
  output logic                     out_found
);

  logic [ELEM_WIDTH-1:0] mem [DEPTH];
  logic [ELEM_WIDTH-1:0] rd_data_r;
  logic [ELEM_WIDTH-1:0] val_r;
  logic [ELEM_WIDTH-1:0] rv_work_r;
  logic                  found_work_r;
  logic [ELEM_WIDTH-1:0] out_rv_r;
  logic                  out_found_r;
  logic                  match;

  assign match = (rd_data_r == val_r);

  // Entry store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[wr_addr] <= cmd.wr_use_value ? val_r : rd_data_r;
    end
    if (cmd.mem_rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Working result for the request in flight
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      val_r        <= in_value;
      rv_work_r    <= '0;
      found_work_r <= 1'b0;
    end else begin
      if (cmd.load_read) begin
        rv_work_r <= rd_data_r;
      end
      if (cmd.cmp && match) begin
        found_work_r <= 1'b1;
      end
    end
  end

  // Output beat payload, held until the next result is published
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_rv_r    <= rv_work_r;
      out_found_r <= found_work_r;
    end
  end

  assign out_read_value = out_rv_r;
  assign out_found      = out_found_r;

endmodule

// ----- src/pal_ctrl.sv -----
`timescale 1ns / 1ps

module pal_ctrl #(
  parameter int DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 in_op,
  input  logic                       in_write_enable,
  input  logic [$clog2(DEPTH)-1:0]   in_index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [$clog2(DEPTH+1)-1:0] out_length,
  output logic [1:0]                 out_status,
  output pal_pkg::pal_cmd_t          cmd,
  output logic [$clog2(DEPTH)-1:0]   wr_addr,
  output logic [$clog2(DEPTH)-1:0]   rd_addr
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SH_RD  = 4'd1;
  localparam logic [3:0] S_SH_WR  = 4'd2;
  localparam logic [3:0] S_PUT    = 4'd3;
  localparam logic [3:0] S_GET_RD = 4'd4;
  localparam logic [3:0] S_GET_LD = 4'd5;
  localparam logic [3:0] S_SR_RD  = 4'd6;
  localparam logic [3:0] S_SR_CMP = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             up_r, up_nxt;
  logic             grow_r, grow_nxt;
  logic [1:0]       st_r, st_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] out_length_r, out_length_nxt;
  logic [1:0]       out_status_r, out_status_nxt;

  logic [CNT_W-1:0] in_idx_ext;
  logic [CNT_W-1:0] idx_ext;
  logic [CNT_W-1:0] pos_m1;
  logic [CNT_W-1:0] pos_p1;
  logic [CNT_W-1:0] count_m1;

  assign in_idx_ext = CNT_W'(in_index);
  assign idx_ext    = CNT_W'(idx_r);
  assign pos_m1     = pos_r - CNT_ONE;
  assign pos_p1     = pos_r + CNT_ONE;
  assign count_m1   = count_r - CNT_ONE;

  assign in_ready = (state_r == S_IDLE);

  // Sequence one request through the entry store
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    idx_nxt        = idx_r;
    up_nxt         = up_r;
    grow_nxt       = grow_r;
    st_nxt         = st_r;
    out_length_nxt = out_length_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r;
    cmd            = '0;
    wr_addr        = pos_r[IDX_W-1:0];
    rd_addr        = pos_r[IDX_W-1:0];

    // drop the output beat once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          idx_nxt   = in_index;
          st_nxt    = pal_pkg::ST_OK;
          grow_nxt  = 1'b0;
          state_nxt = S_DONE;
          unique case (in_op)
            pal_pkg::OP_CLEAR: begin
              count_nxt = '0;
            end
            pal_pkg::OP_INS_AT: begin
              if (count_r == CNT_FULL) begin
                st_nxt = pal_pkg::ST_FULL;
              end else if (in_idx_ext > count_r) begin
                st_nxt = pal_pkg::ST_RANGE;
              end else begin
                grow_nxt = 1'b1;
                up_nxt   = 1'b1;
                pos_nxt  = count_r;
                state_nxt = (count_r > in_idx_ext) ? S_SH_RD : S_PUT;
              end
            end
            pal_pkg::OP_INS_LAST: begin
              if (count_r == CNT_FULL) begin
                st_nxt = pal_pkg::ST_FULL;
              end else begin
                grow_nxt  = 1'b1;
                idx_nxt   = count_r[IDX_W-1:0];
                state_nxt = S_PUT;
              end
            end
            pal_pkg::OP_DEL_AT: begin
              if (count_r == '0) begin
                st_nxt = pal_pkg::ST_EMPTY;
              end else if (in_idx_ext >= count_r) begin
                st_nxt = pal_pkg::ST_RANGE;
              end else begin
                up_nxt  = 1'b0;
                pos_nxt = in_idx_ext;
                if (in_idx_ext < count_m1) begin
                  state_nxt = S_SH_RD;
                end else begin
                  count_nxt = count_m1;
                end
              end
            end
            pal_pkg::OP_DEL_LAST: begin
              if (count_r == '0) begin
                st_nxt = pal_pkg::ST_EMPTY;
              end else begin
                count_nxt = count_m1;
              end
            end
            pal_pkg::OP_GET_SET: begin
              if (count_r == '0) begin
                st_nxt = pal_pkg::ST_EMPTY;
              end else if (in_idx_ext >= count_r) begin
                st_nxt = pal_pkg::ST_RANGE;
              end else begin
                state_nxt = in_write_enable ? S_PUT : S_GET_RD;
              end
            end
            pal_pkg::OP_SEARCH: begin
              pos_nxt = '0;
              if (count_r != '0) begin
                state_nxt = S_SR_RD;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // fetch the neighbor that moves into the current cell
      S_SH_RD: begin
        cmd.mem_rd = 1'b1;
        rd_addr    = up_r ? pos_m1[IDX_W-1:0] : pos_p1[IDX_W-1:0];
        state_nxt  = S_SH_WR;
      end

      // store it and advance along the row
      S_SH_WR: begin
        cmd.mem_wr = 1'b1;
        wr_addr    = pos_r[IDX_W-1:0];
        if (up_r) begin
          pos_nxt   = pos_m1;
          state_nxt = (pos_m1 > idx_ext) ? S_SH_RD : S_PUT;
        end else begin
          pos_nxt = pos_p1;
          if (pos_p1 < count_m1) begin
            state_nxt = S_SH_RD;
          end else begin
            count_nxt = count_m1;
            state_nxt = S_DONE;
          end
        end
      end

      S_PUT: begin
        cmd.mem_wr       = 1'b1;
        cmd.wr_use_value = 1'b1;
        wr_addr          = idx_r;
        if (grow_r) begin
          count_nxt = count_r + CNT_ONE;
        end
        state_nxt = S_DONE;
      end

      S_GET_RD: begin
        cmd.mem_rd = 1'b1;
        rd_addr    = idx_r;
        state_nxt  = S_GET_LD;
      end

      S_GET_LD: begin
        cmd.load_read = 1'b1;
        state_nxt     = S_DONE;
      end

      S_SR_RD: begin
        cmd.mem_rd = 1'b1;
        rd_addr    = pos_r[IDX_W-1:0];
        state_nxt  = S_SR_CMP;
      end

      S_SR_CMP: begin
        cmd.cmp   = 1'b1;
        pos_nxt   = pos_p1;
        state_nxt = (pos_p1 < count_r) ? S_SR_RD : S_DONE;
      end

      // publish once the output register is free
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.publish    = 1'b1;
          out_valid_nxt  = 1'b1;
          out_length_nxt = count_r;
          out_status_nxt = st_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request context and output beat fields
  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    idx_r        <= idx_nxt;
    up_r         <= up_nxt;
    grow_r       <= grow_nxt;
    st_r         <= st_nxt;
    out_length_r <= out_length_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_length = out_length_r;
  assign out_status = out_status_r;

endmodule

// ----- src/packed_array_list_engine.sv -----
`timescale 1ns / 1ps

// Packed ordered list of up to DEPTH entries of ELEM_WIDTH bits, kept in a
// single-port-write, single-port-read memory from entry 0 upward, with an
// element count. One request is worked at a time; a new request is taken
// while the previous result still waits on the output register. The one
// memory read port sets the pace: every entry moved or scanned takes a read
// step, then a write or compare step. Get reads the entry, then loads it;
// insert_at moves each entry from the index upward up by one, then writes
// the value; delete_at moves each entry above the index down by one; search
// compares every entry. Refused requests (full, empty, bad index) leave the
// list unchanged. No clearing pass runs after reset: only entries below the
// count are ever read.
module packed_array_list_engine #(
  parameter int DEPTH      = 32,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 in_op,
  input  logic                       in_write_enable,
  input  logic [$clog2(DEPTH)-1:0]   in_index,
  input  logic [ELEM_WIDTH-1:0]      in_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ELEM_WIDTH-1:0]      out_read_value,
  output logic                       out_found,
  output logic [$clog2(DEPTH+1)-1:0] out_length,
  output logic [1:0]                 out_status
);

  pal_pkg::pal_cmd_t          cmd;
  logic [$clog2(DEPTH)-1:0]   wr_addr;
  logic [$clog2(DEPTH)-1:0]   rd_addr;

  pal_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_write_enable(in_write_enable),
    .in_index       (in_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_length     (out_length),
    .out_status     (out_status),
    .cmd            (cmd),
    .wr_addr        (wr_addr),
    .rd_addr        (rd_addr)
  );

  pal_dpath #(
    .DEPTH     (DEPTH),
    .ELEM_WIDTH(ELEM_WIDTH)
  ) u_dpath (
    .clk           (clk),
    .cmd           (cmd),
    .wr_addr       (wr_addr),
    .rd_addr       (rd_addr),
    .in_value      (in_value),
    .out_read_value(out_read_value),
    .out_found     (out_found)
  );

endmodule

// ----- src/pal_checker.sv -----
`timescale 1ns / 1ps
`include "packed_array_list_engine_macros.svh"

module pal_checker #(
  parameter int DEPTH      = 32,
  parameter int ELEM_WIDTH = 16
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ELEM_WIDTH-1:0]      out_read_value,
  input logic                       out_found,
  input logic [$clog2(DEPTH+1)-1:0] out_length,
  input logic [1:0]                 out_status
);

  localparam logic [$clog2(DEPTH+1)-1:0] LEN_MAX = ($clog2(DEPTH+1))'(DEPTH);
  localparam int BEAT_W = ELEM_WIDTH + $clog2(DEPTH + 1) + 3;

  logic [BEAT_W-1:0] out_beat;
  logic              st_ok;
  logic              st_empty;
  logic              len_zero;

  // Gather the result beat fields and status flags
  assign out_beat = {out_read_value, out_found, out_length, out_status};
  assign st_ok    = (out_status == pal_pkg::ST_OK);
  assign st_empty = (out_status == pal_pkg::ST_EMPTY);
  assign len_zero = (out_length == '0);

  // stalled output beat holds
  `PAL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_beat))

  // length never exceeds the capacity
  `PAL_ASSERT_NOW(a_len_max, clk, rst_n, out_valid, out_length <= LEN_MAX)

  // a hit needs a successful request on a non-empty list
  `PAL_ASSERT_NOW(a_found_ok, clk, rst_n, out_valid && out_found, st_ok && !len_zero)

  // an empty refusal reports an empty list
  `PAL_ASSERT_NOW(a_empty_len, clk, rst_n, out_valid && st_empty, len_zero)

  // read data only comes from a successful request
  `PAL_ASSERT_NOW(a_rd_ok, clk, rst_n, out_valid && (out_read_value != '0), st_ok)

endmodule

bind packed_array_list_engine pal_checker #(
  .DEPTH     (DEPTH),
  .ELEM_WIDTH(ELEM_WIDTH)
) u_pal_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_read_value(out_read_value),
  .out_found     (out_found),
  .out_length    (out_length),
  .out_status    (out_status)
);
